>>> hw/rtl/http_request_byte_tagger_top_defines.svh
// Assertion macros for the request byte tagger
`ifndef HTTP_REQUEST_BYTE_TAGGER_TOP_DEFINES_SVH
`define HTTP_REQUEST_BYTE_TAGGER_TOP_DEFINES_SVH

// Check an implication on every clock edge outside reset
`define HTAG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("htag check failed");

// Same check with a message of its own
`define HTAG_ASSERT_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

>>> hw/rtl/htag_pkg.sv
package htag_pkg;

   typedef enum logic [3:0] {
      PH_METHOD   = 4'd0,
      PH_PATH     = 4'd1,
      PH_QKEY     = 4'd2,
      PH_QVAL     = 4'd3,
      PH_PROTO    = 4'd4,
      PH_PROTO_LF = 4'd5,
      PH_HNAME    = 4'd6,
      PH_HSKIP    = 4'd7,
      PH_HVAL     = 4'd8,
      PH_HLF      = 4'd9,
      PH_BODY_LF  = 4'd10,
      PH_BODY     = 4'd11,
      PH_IGNORE   = 4'd12
   } phase_type;

   localparam logic [3:0] CL_METHOD  = 4'd0;
   localparam logic [3:0] CL_PATH    = 4'd1;
   localparam logic [3:0] CL_QKEY    = 4'd2;
   localparam logic [3:0] CL_QVAL    = 4'd3;
   localparam logic [3:0] CL_PROTO   = 4'd4;
   localparam logic [3:0] CL_HNAME   = 4'd5;
   localparam logic [3:0] CL_HVAL    = 4'd6;
   localparam logic [3:0] CL_BODY    = 4'd7;
   localparam logic [3:0] CL_DELIM   = 4'd8;
   localparam logic [3:0] CL_IGNORED = 4'd9;

   localparam logic [2:0] MC_UNKNOWN = 3'd0;

   localparam int unsigned NUM_VERBS = 7;
   localparam logic [6:0]  ALL_CANDIDATES = 7'h7F;
   localparam logic [3:0]  POS_MAX = 4'd15;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [7:0] VERB_TEXT [NUM_VERBS][8] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00}
   };

   localparam logic [3:0] VERB_LEN [NUM_VERBS] = '{
      4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd5, 4'd7
   };

   typedef struct packed {
      logic narrow;
      logic clear;
   } method_ctrl_type;

   typedef struct packed {
      logic [3:0] field_class;
      logic       method_done;
      logic [2:0] method_code;
      logic       message_end;
   } result_type;

endpackage

>>> hw/rtl/htag_method.sv
module htag_method (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               in_byte,
   input  htag_pkg::method_ctrl_type ctrl,
   output logic [2:0]               method_code
);
   import htag_pkg::*;

   logic [6:0] cand_ff, cand_in;
   logic [3:0] pos_ff, pos_in;
   logic [6:0] keep;

   always_comb begin
      for (int i = 0; i < NUM_VERBS; i++) begin
         keep[i] = (pos_ff < VERB_LEN[i]) && (VERB_TEXT[i][pos_ff[2:0]] == in_byte);
      end
   end

   always_comb begin
      cand_in = cand_ff;
      pos_in  = pos_ff;
      if (ctrl.clear) begin
         cand_in = ALL_CANDIDATES;
         pos_in  = 4'd0;
      end else if (ctrl.narrow) begin
         cand_in = cand_ff & keep;
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_comb begin
      method_code = MC_UNKNOWN;
      for (int i = NUM_VERBS - 1; i >= 0; i--) begin
         if (cand_ff[i] && (pos_ff == VERB_LEN[i])) begin
            method_code = 3'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= ALL_CANDIDATES;
         pos_ff  <= 4'd0;
      end else if (step) begin
         cand_ff <= cand_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

>>> hw/rtl/htag_parser.sv
module htag_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                in_byte,
   input  logic                      end_of_message,
   input  logic [2:0]                method_code,
   output htag_pkg::method_ctrl_type ctrl,
   output htag_pkg::result_type      result
);
   import htag_pkg::*;

   phase_type phase_ff, phase_in;
   logic      line_start_ff, line_start_in;

   // next phase
   always_comb begin
      phase_in      = phase_ff;
      line_start_in = line_start_ff;
      unique case (phase_ff)
         PH_PATH: begin
            if (in_byte == CH_QUERY) begin
               phase_in = PH_QKEY;
            end else if (in_byte == CH_SPACE) begin
               phase_in = PH_PROTO;
            end
         end
         PH_QKEY: begin
            if (in_byte == CH_EQUAL) begin
               phase_in = PH_QVAL;
            end else if (in_byte == CH_SPACE) begin
               phase_in = PH_PROTO;
            end
         end
         PH_QVAL: begin
            if (in_byte == CH_AMP) begin
               phase_in = PH_QKEY;
            end else if (in_byte == CH_SPACE) begin
               phase_in = PH_PROTO;
            end
         end
         PH_PROTO: begin
            if (in_byte == CH_CR) begin
               phase_in = PH_PROTO_LF;
            end
         end
         PH_PROTO_LF, PH_HLF: begin
            phase_in      = PH_HNAME;
            line_start_in = 1'b1;
         end
         PH_HNAME: begin
            if (line_start_ff && in_byte == CH_CR) begin
               phase_in = PH_BODY_LF;
            end else if (in_byte == CH_COLON) begin
               phase_in = PH_HSKIP;
            end
            line_start_in = 1'b0;
         end
         PH_HSKIP: begin
            phase_in = PH_HVAL;
         end
         PH_HVAL: begin
            if (in_byte == CH_CR) begin
               phase_in = PH_HLF;
            end
         end
         PH_BODY_LF: begin
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            if (in_byte == CH_NUL) begin
               phase_in = PH_IGNORE;
            end
         end
         PH_IGNORE: begin
            phase_in = PH_IGNORE;
         end
         default: begin
            if (in_byte == CH_SPACE) begin
               phase_in = PH_PATH;
            end else begin
               phase_in = PH_METHOD;
            end
         end
      endcase
      if (end_of_message) begin
         phase_in      = PH_METHOD;
         line_start_in = 1'b0;
      end
   end

   // tag and method control
   always_comb begin
      result.field_class = CL_DELIM;
      result.method_done = 1'b0;
      result.method_code = MC_UNKNOWN;
      result.message_end = end_of_message;
      ctrl.narrow        = 1'b0;
      ctrl.clear         = end_of_message;
      unique case (phase_ff)
         PH_PATH: begin
            if (in_byte != CH_QUERY && in_byte != CH_SPACE) begin
               result.field_class = CL_PATH;
            end
         end
         PH_QKEY: begin
            if (in_byte != CH_EQUAL && in_byte != CH_SPACE && in_byte != CH_AMP) begin
               result.field_class = CL_QKEY;
            end
         end
         PH_QVAL: begin
            if (in_byte != CH_AMP && in_byte != CH_SPACE) begin
               result.field_class = CL_QVAL;
            end
         end
         PH_PROTO: begin
            if (in_byte != CH_CR) begin
               result.field_class = CL_PROTO;
            end
         end
         PH_PROTO_LF, PH_HLF, PH_HSKIP, PH_BODY_LF: begin
            result.field_class = CL_DELIM;
         end
         PH_HNAME: begin
            if (!(line_start_ff && in_byte == CH_CR) && in_byte != CH_COLON) begin
               result.field_class = CL_HNAME;
            end
         end
         PH_HVAL: begin
            if (in_byte != CH_CR) begin
               result.field_class = CL_HVAL;
            end
         end
         PH_BODY: begin
            if (in_byte == CH_NUL) begin
               result.message_end = 1'b1;
            end else begin
               result.field_class = CL_BODY;
            end
         end
         PH_IGNORE: begin
            result.field_class = CL_IGNORED;
         end
         default: begin
            if (in_byte == CH_SPACE) begin
               result.method_done = 1'b1;
               result.method_code = method_code;
               ctrl.clear         = 1'b1;
            end else begin
               result.field_class = CL_METHOD;
               ctrl.narrow        = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_METHOD;
         line_start_ff <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         line_start_ff <= line_start_in;
      end
   end

endmodule

>>> hw/rtl/http_request_byte_tagger_top.sv
// A word accepted is held in the input register, then moves to the output register
// that drives rsp_. One word per cycle unless rsp_ready stalls the output; the
// parse state loop closes through the phase and method candidate registers.
// Reset: synchronous, active high; clears the valid flags of both registers and
// returns the parser to the method phase with all method candidates set.
module http_request_byte_tagger_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_field_class,
   output logic       rsp_method_done,
   output logic [2:0] rsp_method_code,
   output logic       rsp_message_end
);
   import htag_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_eom_ff;
   logic            out_valid_ff;
   logic [7:0]      out_byte_ff;
   result_type      out_result_ff;
   logic            out_free;
   logic            step;
   logic [2:0]      method_code;
   method_ctrl_type ctrl;
   result_type      result;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   htag_method u_method (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .in_byte     (in_byte_ff),
      .ctrl        (ctrl),
      .method_code (method_code)
   );

   htag_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .in_byte        (in_byte_ff),
      .end_of_message (in_eom_ff),
      .method_code    (method_code),
      .ctrl           (ctrl),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eom_ff  <= req_end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_byte_ff   <= in_byte_ff;
         out_result_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_field_class = out_result_ff.field_class;
   assign rsp_method_done = out_result_ff.method_done;
   assign rsp_method_code = out_result_ff.method_code;
   assign rsp_message_end = out_result_ff.message_end;

endmodule

>>> hw/rtl/htag_checker.sv
`include "http_request_byte_tagger_top_defines.svh"

module htag_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [3:0] rsp_field_class,
   input logic       rsp_method_done,
   input logic [2:0] rsp_method_code
);
   import htag_pkg::*;

   `HTAG_ASSERT(a_done_is_delim, clock, reset,
      rsp_valid && rsp_method_done |-> rsp_field_class == CL_DELIM && rsp_out_byte == CH_SPACE)
   `HTAG_ASSERT(a_code_only_when_done, clock, reset,
      rsp_valid && !rsp_method_done |-> rsp_method_code == MC_UNKNOWN)
   `HTAG_ASSERT(a_class_range, clock, reset, rsp_valid |-> rsp_field_class <= CL_IGNORED)
   `HTAG_ASSERT_MSG(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_field_class),
      "rsp word changed while stalled")

endmodule

bind http_request_byte_tagger_top htag_checker u_htag_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_field_class (rsp_field_class),
   .rsp_method_done (rsp_method_done),
   .rsp_method_code (rsp_method_code)
);
